/* sv/ptom_pkg.sv */
// Package for the price-time order matcher: sizes, result codes, opcodes, scan results.
// No dependencies.
package ptom_pkg;
	localparam int MAX_ORDERS = 32;
	localparam int SLOT_W = $clog2(MAX_ORDERS);
	localparam int MAX_RESULTS = 32;
	localparam int RCNT_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_CANCEL = 2'd1,
		OP_MODIFY = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		RK_TRADE = 3'd0,
		RK_ACCEPTED = 3'd1,
		RK_ZERO_QTY = 3'd2,
		RK_DUPLICATE = 3'd3,
		RK_UNKNOWN = 3'd4,
		RK_INCREASE = 3'd5,
		RK_FULL = 3'd6
	} result_kind_t;

	// Scan results handed from the slot scanner to the sequencer.
	typedef struct packed {
		logic id_hit;
		logic [SLOT_W-1:0] id_slot;
		logic free_hit;
		logic [SLOT_W-1:0] free_slot;
		logic bid_hit;
		logic [SLOT_W-1:0] bid_slot;
		logic ask_hit;
		logic [SLOT_W-1:0] ask_slot;
	} scan_res_t;
endpackage

/* sv/price_time_order_matcher.sv */
// Top level of the price-time order matcher: slot store, sequencer, output
// register. Depends on ptom_pkg and ptom_scanner.
//
//  channel | direction | payload
//  in      | in        | opcode, order_id, is_buy, price, quantity
//  out     | out       | result_kind .. last_result, one per trade (first 31) plus status
//
// A request runs one scan for the id and free slot, then one after the update
// for the front prices; each trade adds one more scan. The single scanner over
// the slot store sets the rate; one request at a time.
// Reset clears slot valid bits, the arrival counter and the running volume.
// A stall on the output holds the status write and the scan after a trade.
module price_time_order_matcher (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] opcode,
	input logic [63:0] order_id,
	input logic is_buy,
	input logic [31:0] price,
	input logic [31:0] quantity,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] result_kind,
	output logic [63:0] buy_order_id,
	output logic [63:0] sell_order_id,
	output logic [31:0] trade_price,
	output logic [31:0] trade_quantity,
	output logic [31:0] best_bid,
	output logic [31:0] best_ask,
	output logic both_sides_present,
	output logic [63:0] total_volume,
	output logic last_result
);
	import ptom_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOOKUP, ST_APPLY, ST_MSCAN, ST_MATCH, ST_EMIT, ST_FSCAN, ST_STATUS
	} state_t;

	// slot store: valid bits in flops, payload undefined until written
	logic [MAX_ORDERS-1:0] valid_q;
	logic [63:0] id_mem [MAX_ORDERS];
	logic buy_mem [MAX_ORDERS];
	logic [31:0] price_mem [MAX_ORDERS];
	logic [31:0] rem_mem [MAX_ORDERS];
	logic [39:0] arr_mem [MAX_ORDERS];

	state_t state_q;
	logic [1:0] op_q;
	logic [63:0] oid_q;
	logic buy_q;
	logic [31:0] price_q, qty_q;
	logic [39:0] arrival_q;
	logic [63:0] volume_q;
	logic [RCNT_W-1:0] rcnt_q;
	result_kind_t kind_q;
	logic [63:0] tb_id_q, ta_id_q;
	logic [31:0] tp_q, tq_q;
	logic pend_q;
	logic scan_start;
	logic scan_done;
	logic [SLOT_W-1:0] scan_idx;
	scan_res_t sr;
	logic [31:0] bq, aq, q;
	logic out_free;
	logic load_trade;
	logic load_status;

	ptom_scanner u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start), .key_id(oid_q),
		.slot_valid(valid_q[scan_idx]), .slot_id(id_mem[scan_idx]),
		.slot_buy(buy_mem[scan_idx]), .slot_price(price_mem[scan_idx]),
		.slot_arrival(arr_mem[scan_idx]), .index(scan_idx), .done(scan_done), .res(sr)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign bq = rem_mem[sr.bid_slot];
	assign aq = rem_mem[sr.ask_slot];
	assign q = (bq < aq) ? bq : aq;

	// output register is free when empty or being taken this cycle
	assign out_free = !out_valid || !out_stall;
	// a trade leaves once the scan after it has the new front prices
	assign load_trade = (state_q == ST_MSCAN) && scan_done && pend_q;
	assign load_status = (state_q == ST_STATUS) && out_free;

	always_comb begin
		scan_start = 1'b0;
		case (state_q)
			ST_IDLE: scan_start = in_valid;
			ST_APPLY: scan_start = 1'b1;
			ST_EMIT: scan_start = out_free;
			default: scan_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_APPLY && op_q == OP_ADD && qty_q != '0 && !sr.id_hit &&
			sr.free_hit) begin
			id_mem[sr.free_slot] <= oid_q;
			buy_mem[sr.free_slot] <= buy_q;
			price_mem[sr.free_slot] <= price_q;
			rem_mem[sr.free_slot] <= qty_q;
			arr_mem[sr.free_slot] <= arrival_q;
		end else if (state_q == ST_APPLY && op_q == OP_MODIFY && qty_q != '0 && sr.id_hit) begin
			if (price_q != price_mem[sr.id_slot]) begin
				price_mem[sr.id_slot] <= price_q;
				rem_mem[sr.id_slot] <= qty_q;
				arr_mem[sr.id_slot] <= arrival_q;
			end else if (qty_q <= rem_mem[sr.id_slot]) begin
				rem_mem[sr.id_slot] <= qty_q;
			end
		end else if (state_q == ST_MATCH) begin
			rem_mem[sr.bid_slot] <= bq - q;
			rem_mem[sr.ask_slot] <= aq - q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			arrival_q <= '0;
			volume_q <= '0;
			rcnt_q <= '0;
			kind_q <= RK_ACCEPTED;
			op_q <= '0;
			oid_q <= '0;
			buy_q <= 1'b0;
			price_q <= '0;
			qty_q <= '0;
			tb_id_q <= '0;
			ta_id_q <= '0;
			tp_q <= '0;
			tq_q <= '0;
			pend_q <= 1'b0;
			out_valid <= 1'b0;
			result_kind <= '0;
			buy_order_id <= '0;
			sell_order_id <= '0;
			trade_price <= '0;
			trade_quantity <= '0;
			best_bid <= '0;
			best_ask <= '0;
			both_sides_present <= 1'b0;
			total_volume <= '0;
			last_result <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q <= opcode;
						oid_q <= order_id;
						buy_q <= is_buy;
						price_q <= price;
						qty_q <= quantity;
						rcnt_q <= '0;
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: if (scan_done) state_q <= ST_APPLY;
				ST_APPLY: begin
					case (op_q)
						OP_ADD: begin
							if (qty_q == '0) begin
								kind_q <= RK_ZERO_QTY;
								state_q <= ST_FSCAN;
							end else if (sr.id_hit) begin
								kind_q <= RK_DUPLICATE;
								state_q <= ST_FSCAN;
							end else if (!sr.free_hit) begin
								kind_q <= RK_FULL;
								state_q <= ST_FSCAN;
							end else begin
								kind_q <= RK_ACCEPTED;
								valid_q[sr.free_slot] <= 1'b1;
								arrival_q <= arrival_q + 40'd1;
								state_q <= ST_MSCAN;
							end
						end
						OP_CANCEL: begin
							state_q <= ST_FSCAN;
							if (!sr.id_hit) begin
								kind_q <= RK_UNKNOWN;
							end else begin
								kind_q <= RK_ACCEPTED;
								valid_q[sr.id_slot] <= 1'b0;
							end
						end
						OP_MODIFY: begin
							if (!sr.id_hit) begin
								kind_q <= RK_UNKNOWN;
								state_q <= ST_FSCAN;
							end else if (qty_q == '0) begin
								// quantity zero acts as a cancel
								kind_q <= RK_ACCEPTED;
								valid_q[sr.id_slot] <= 1'b0;
								state_q <= ST_FSCAN;
							end else if (price_q != price_mem[sr.id_slot]) begin
								kind_q <= RK_ACCEPTED;
								arrival_q <= arrival_q + 40'd1;
								state_q <= ST_MSCAN;
							end else if (qty_q > rem_mem[sr.id_slot]) begin
								kind_q <= RK_INCREASE;
								state_q <= ST_FSCAN;
							end else begin
								kind_q <= RK_ACCEPTED;
								state_q <= ST_FSCAN;
							end
						end
						default: begin
							kind_q <= RK_UNKNOWN;
							state_q <= ST_FSCAN;
						end
					endcase
				end
				ST_MSCAN: begin
					if (scan_done) begin
						pend_q <= 1'b0;
						if (sr.bid_hit && sr.ask_hit &&
							price_mem[sr.bid_slot] >= price_mem[sr.ask_slot])
							state_q <= ST_MATCH;
						else
							state_q <= ST_STATUS;
					end
				end
				ST_MATCH: begin
					tb_id_q <= id_mem[sr.bid_slot];
					ta_id_q <= id_mem[sr.ask_slot];
					tp_q <= price_mem[sr.ask_slot];
					tq_q <= q;
					volume_q <= volume_q + 64'(q);
					if (bq == q) valid_q[sr.bid_slot] <= 1'b0;
					if (aq == q) valid_q[sr.ask_slot] <= 1'b0;
					// trades past the 31st still run but are not sent
					pend_q <= (rcnt_q < RCNT_W'(MAX_RESULTS - 1));
					if (rcnt_q < RCNT_W'(MAX_RESULTS - 1))
						rcnt_q <= rcnt_q + RCNT_W'(1);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// next scan both decides on more trades and gives the prices
					if (out_free) state_q <= ST_MSCAN;
				end
				ST_FSCAN: state_q <= ST_MSCAN;
				ST_STATUS: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase

			if (load_trade || load_status) begin
				out_valid <= 1'b1;
				result_kind <= load_trade ? RK_TRADE : kind_q;
				buy_order_id <= load_trade ? tb_id_q : '0;
				sell_order_id <= load_trade ? ta_id_q : '0;
				trade_price <= load_trade ? tp_q : '0;
				trade_quantity <= load_trade ? tq_q : '0;
				best_bid <= sr.bid_hit ? price_mem[sr.bid_slot] : '0;
				best_ask <= sr.ask_hit ? price_mem[sr.ask_slot] : '0;
				both_sides_present <= sr.bid_hit && sr.ask_hit;
				total_volume <= volume_q;
				last_result <= !load_trade;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("took request while busy");
	a_trade_vol: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MATCH |=> volume_q == $past(volume_q) + 64'($past(q)))
		else $error("volume not updated");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STATUS && !(out_valid && out_stall) |=> state_q == ST_IDLE)
		else $error("status did not end request");
	a_trade_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_trade |-> !out_valid) else $error("trade overwrote pending result");
endmodule

/* sv/ptom_scanner.sv */
// Slot scanner: one compare unit visits one slot per cycle and tracks id,
// free slot, front bid and front ask. Depends on ptom_pkg.
module ptom_scanner (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] key_id,
	input logic slot_valid,
	input logic [63:0] slot_id,
	input logic slot_buy,
	input logic [31:0] slot_price,
	input logic [39:0] slot_arrival,
	output logic [ptom_pkg::SLOT_W-1:0] index,
	output logic done,
	output ptom_pkg::scan_res_t res
);
	import ptom_pkg::*;

	logic busy_q;
	logic [SLOT_W-1:0] idx_q;
	scan_res_t res_q;
	logic [31:0] bid_price_q, ask_price_q;
	logic [39:0] bid_arr_q, ask_arr_q;
	logic better_bid, better_ask;

	assign index = idx_q;
	assign res = res_q;

	// equal price goes to the earlier arrival; strict improvement keeps the lower index on full ties
	always_comb begin
		better_bid = !res_q.bid_hit || slot_price > bid_price_q ||
			(slot_price == bid_price_q && slot_arrival < bid_arr_q);
		better_ask = !res_q.ask_hit || slot_price < ask_price_q ||
			(slot_price == ask_price_q && slot_arrival < ask_arr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			done <= 1'b0;
			res_q <= '0;
			bid_price_q <= '0;
			ask_price_q <= '0;
			bid_arr_q <= '0;
			ask_arr_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q <= '0;
			done <= 1'b0;
			res_q <= '0;
		end else if (busy_q) begin
			if (slot_valid) begin
				if (!res_q.id_hit && slot_id == key_id) begin
					res_q.id_hit <= 1'b1;
					res_q.id_slot <= idx_q;
				end
				if (slot_buy && better_bid) begin
					res_q.bid_hit <= 1'b1;
					res_q.bid_slot <= idx_q;
					bid_price_q <= slot_price;
					bid_arr_q <= slot_arrival;
				end
				if (!slot_buy && better_ask) begin
					res_q.ask_hit <= 1'b1;
					res_q.ask_slot <= idx_q;
					ask_price_q <= slot_price;
					ask_arr_q <= slot_arrival;
				end
			end else if (!res_q.free_hit) begin
				res_q.free_hit <= 1'b1;
				res_q.free_slot <= idx_q;
			end
			if (idx_q == SLOT_W'(MAX_ORDERS - 1)) begin
				busy_q <= 1'b0;
				done <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
				done <= 1'b0;
			end
		end else begin
			done <= 1'b0;
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("scan done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && idx_q == '0) else $error("scan did not start");
	a_bid_buy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(res_q.bid_hit && res_q.ask_hit && res_q.bid_slot == res_q.ask_slot))
		else $error("same slot on both sides");
endmodule
